// ===== rtl/core/bpra_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package bpra_pkg;

    // payload widths
    localparam int SIZE_W   = 32;
    localparam int ID_W     = 8;
    localparam int BLOCK_W  = 16;
    localparam int LIMIT_W  = 9;
    localparam int RESV_W   = 10;
    localparam int AVAIL_W  = 10;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // reset values of the configuration registers
    localparam logic [BLOCK_W-1:0] BLOCK_BYTES_RST = BLOCK_W'(4066);
    localparam logic [LIMIT_W-1:0] POOL_LIMIT_RST  = LIMIT_W'(256);

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_BYTES = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_POOL_LIMIT  = CFG_IDX_W'(1);

    typedef enum logic [1:0] {
        OP_RESERVE  = 2'd0,
        OP_RELEASE  = 2'd1,
        OP_ALLOCATE = 2'd2,
        OP_FREE     = 2'd3
    } t_opcode;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_REFUSED   = 2'd1,
        ST_UNDERFLOW = 2'd2,
        ST_QUEUE_FULL = 2'd3
    } t_status;

endpackage

`default_nettype wire

// ===== rtl/core/bpra_cfg_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface bpra_cfg_if;
    import bpra_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/bpra_in_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface bpra_in_if;
    import bpra_pkg::*;

    logic              valid;
    logic              ready;
    t_opcode           opcode;
    logic [SIZE_W-1:0] module_size;
    logic [ID_W-1:0]   buffer_id;

    modport source (output valid, output opcode, output module_size, output buffer_id,
                    input ready);
    modport sink   (input valid, input opcode, input module_size, input buffer_id,
                    output ready);
endinterface

`default_nettype wire

// ===== rtl/core/bpra_out_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface bpra_out_if;
    import bpra_pkg::*;

    logic               valid;
    logic               ready;
    t_status            status;
    logic [ID_W-1:0]    granted_id;
    logic [SIZE_W-1:0]  blocks_needed;
    logic [AVAIL_W-1:0] available_blocks;
    logic               fits_pool;

    modport source (output valid, output status, output granted_id, output blocks_needed,
                    output available_blocks, output fits_pool, input ready);
    modport sink   (input valid, input status, input granted_id, input blocks_needed,
                    input available_blocks, input fits_pool, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/block_pool_reservation_allocator_top.sv =====
// Buffer pool allocator with reservation accounting. Each input transaction carries
// one opcode (reserve, release, allocate, free) and yields exactly one result
// transaction. The block works on one transaction at a time: it is accepted in the
// idle state, the block need is found by a restoring divider that produces one
// quotient bit per cycle, then a rounding step, an update step on the counters and
// the free-id queue memory, and a final step that forms the available count and
// waits until the output register is free. The result sits in an output register,
// and the next transaction is taken while it waits to be collected.
// Recycled ids live in a POOL_DEPTH x 8 synchronous memory used as a circular FIFO;
// it needs no clearing after reset, since an entry is only read after it was written.
// Configuration writes are always accepted and must only happen while idle.
`timescale 1ns / 1ps
`default_nettype none

module block_pool_reservation_allocator_top #(
    parameter int POOL_DEPTH = 256
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    bpra_cfg_if.sink    i_cfg,
    bpra_in_if.sink     i_in,
    bpra_out_if.source  o_out
);
    import bpra_pkg::*;

    localparam int PTR_W  = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
    localparam int FILL_W = $clog2(POOL_DEPTH + 1);
    localparam int SUM_W  = ((FILL_W > AVAIL_W) ? FILL_W : AVAIL_W) + 2;
    localparam logic [PTR_W-1:0]  PTR_LAST = PTR_W'(POOL_DEPTH - 1);
    localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(POOL_DEPTH);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_DIV  = 5'b00010,
        S_CEIL = 5'b00100,
        S_EXEC = 5'b01000,
        S_FIN  = 5'b10000
    } t_state;

    t_state r_state, n_state;

    // configuration registers
    logic [BLOCK_W-1:0] r_block_bytes;
    logic [LIMIT_W-1:0] r_pool_limit;

    // pool state
    logic [LIMIT_W-1:0] r_created;
    logic [RESV_W-1:0]  r_reserved;
    logic [PTR_W-1:0]   r_head;
    logic [PTR_W-1:0]   r_tail;
    logic [FILL_W-1:0]  r_fill;

    // captured transaction
    t_opcode            r_op;
    logic [ID_W-1:0]    r_id;

    // divider
    logic [SIZE_W-1:0]  r_dq;
    logic [BLOCK_W-1:0] r_rem;
    logic [BLOCK_W-1:0] r_divisor;
    logic [4:0]         r_cnt;
    logic [BLOCK_W:0]   w_trial;
    logic [SIZE_W-1:0]  r_need;

    // result fields
    t_status            r_status;
    logic [ID_W-1:0]    r_granted;
    logic               r_out_valid;
    t_status            r_out_status;
    logic [ID_W-1:0]    r_out_granted;
    logic [SIZE_W-1:0]  r_out_need;
    logic [AVAIL_W-1:0] r_out_avail;
    logic               r_out_fits;

    // free-id queue memory
    logic [ID_W-1:0]    r_mem [POOL_DEPTH];
    logic [ID_W-1:0]    r_rd_data;
    logic               w_mem_we;

    logic               w_in_acc;
    logic               w_out_free;
    logic signed [SUM_W-1:0] w_sum;
    logic [AVAIL_W-1:0] w_avail;

    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = (r_state == S_IDLE);
    assign w_in_acc    = i_in.valid && (r_state == S_IDLE);
    assign w_out_free  = !r_out_valid || o_out.ready;

    assign o_out.valid            = r_out_valid;
    assign o_out.status           = r_out_status;
    assign o_out.granted_id       = r_out_granted;
    assign o_out.blocks_needed    = r_out_need;
    assign o_out.available_blocks = r_out_avail;
    assign o_out.fits_pool        = r_out_fits;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_block_bytes <= BLOCK_BYTES_RST;
            r_pool_limit  <= POOL_LIMIT_RST;
        end else if (i_cfg.valid) begin
            if (i_cfg.index == CFG_BLOCK_BYTES) begin
                r_block_bytes <= i_cfg.data[BLOCK_W-1:0];
            end else if (i_cfg.index == CFG_POOL_LIMIT) begin
                r_pool_limit <= i_cfg.data[LIMIT_W-1:0];
            end
        end
    end

    // available count from current state, floored at zero
    always_comb begin
        w_sum = SUM_W'(r_pool_limit) - SUM_W'(r_created) + SUM_W'(r_fill)
              - SUM_W'(r_reserved);
        w_avail = w_sum[SUM_W-1] ? '0 : w_sum[AVAIL_W-1:0];
    end

    // restoring divider trial subtraction
    assign w_trial = {r_rem, r_dq[SIZE_W-1]} - {1'b0, r_divisor};

    // state sequencing
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (w_in_acc) n_state = S_DIV;
            S_DIV:  if (r_cnt == 5'd31) n_state = S_CEIL;
            S_CEIL: n_state = S_EXEC;
            S_EXEC: n_state = S_FIN;
            S_FIN:  if (w_out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // capture and divide
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_op      <= i_in.opcode;
            r_id      <= i_in.buffer_id;
            r_dq      <= i_in.module_size;
            r_rem     <= '0;
            r_divisor <= r_block_bytes;
            r_cnt     <= '0;
        end else if (r_state == S_DIV) begin
            r_cnt <= r_cnt + 5'd1;
            if (!w_trial[BLOCK_W]) begin
                r_rem <= w_trial[BLOCK_W-1:0];
                r_dq  <= {r_dq[SIZE_W-2:0], 1'b1};
            end else begin
                r_rem <= {r_rem[BLOCK_W-2:0], r_dq[SIZE_W-1]};
                r_dq  <= {r_dq[SIZE_W-2:0], 1'b0};
            end
        end
    end

    // round the quotient up to whole blocks
    always_ff @(posedge i_clk) begin
        if (r_state == S_CEIL) begin
            if (r_divisor == '0) begin
                r_need <= '1;
            end else begin
                r_need <= r_dq + SIZE_W'(r_rem != '0);
            end
        end
    end

    // queue memory: read at head every cycle, write at tail on a push
    assign w_mem_we = (r_state == S_EXEC) && (r_op == OP_FREE) && (r_fill != FILL_MAX);

    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_mem[r_tail] <= r_id;
        end
        r_rd_data <= r_mem[r_head];
    end

    // apply the operation to the pool state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_created  <= '0;
            r_reserved <= '0;
            r_head     <= '0;
            r_tail     <= '0;
            r_fill     <= '0;
        end else if (r_state == S_EXEC) begin
            unique case (r_op)
                OP_RESERVE: begin
                    if (r_need < SIZE_W'(w_avail)) begin
                        r_reserved <= r_reserved + r_need[RESV_W-1:0];
                    end
                end
                OP_RELEASE: begin
                    if (SIZE_W'(r_reserved) >= r_need) begin
                        r_reserved <= r_reserved - r_need[RESV_W-1:0];
                    end else begin
                        r_reserved <= '0;
                    end
                end
                OP_ALLOCATE: begin
                    if (r_fill != '0) begin
                        r_head <= (r_head == PTR_LAST) ? '0 : r_head + PTR_W'(1);
                        r_fill <= r_fill - FILL_W'(1);
                    end else if (r_created < r_pool_limit) begin
                        r_created <= r_created + LIMIT_W'(1);
                    end
                end
                OP_FREE: begin
                    if (r_fill != FILL_MAX) begin
                        r_tail <= (r_tail == PTR_LAST) ? '0 : r_tail + PTR_W'(1);
                        r_fill <= r_fill + FILL_W'(1);
                    end
                end
                default: ;
            endcase
        end
    end

    // status and granted id of the operation
    always_ff @(posedge i_clk) begin
        if (r_state == S_EXEC) begin
            r_status  <= ST_OK;
            r_granted <= '0;
            unique case (r_op)
                OP_RESERVE: begin
                    if (!(r_need < SIZE_W'(w_avail))) r_status <= ST_REFUSED;
                end
                OP_RELEASE: begin
                    if (SIZE_W'(r_reserved) < r_need) r_status <= ST_UNDERFLOW;
                end
                OP_ALLOCATE: begin
                    if (r_fill != '0) begin
                        r_granted <= r_rd_data;
                    end else if (r_created < r_pool_limit) begin
                        r_granted <= r_created[ID_W-1:0];
                    end else begin
                        r_status <= ST_REFUSED;
                    end
                end
                OP_FREE: begin
                    if (r_fill == FILL_MAX) r_status <= ST_QUEUE_FULL;
                end
                default: ;
            endcase
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == S_FIN) && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_FIN) && w_out_free) begin
            r_out_status  <= r_status;
            r_out_granted <= r_granted;
            r_out_need    <= r_need;
            r_out_avail   <= w_avail;
            r_out_fits    <= (r_need < SIZE_W'(r_pool_limit));
        end
    end

endmodule

`default_nettype wire
